FILE: rtl/pcg_pkg.sv
// Shared types and constants for the plane contact generator.
// Used by pcg_pipe, pcg_emit and plane_contact_generator; no dependencies.
`default_nettype none

package pcg_pkg;

    localparam int NRM_W      = 16;               // Q1.15 normal component
    localparam int NRM_FRAC   = 15;
    localparam int POS_W      = 32;               // Q16.16 coordinate
    localparam int SIZE_W     = 31;               // radius / half size
    localparam int PEN_W      = 31;
    localparam int NAXIS      = 3;
    localparam int NCORNER    = 8;
    localparam int CORNER_W   = 3;
    localparam int CTR_W      = POS_W + 1;        // pos + mount
    localparam int OFS_W      = POS_W + 1;        // half size or negated sphere offset
    localparam int PT_W       = CTR_W + 2;        // center +/- offset before saturation

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 320;
    localparam int M_TDATA_W  = 136;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_D  = 2'd3;

    localparam logic [NRM_W-1:0] NORMAL_X_RST = 16'h0000;
    localparam logic [NRM_W-1:0] NORMAL_Y_RST = 16'h7FFF;
    localparam logic [NRM_W-1:0] NORMAL_Z_RST = 16'h0000;
    localparam logic [POS_W-1:0] PLANE_D_RST  = 32'h0000_0000;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic signed [POS_W-1:0] offset;
    } t_plane;

    typedef struct packed {
        logic                              box;
        logic [NAXIS-1:0][POS_W-1:0]       pos;
        logic [NAXIS-1:0][POS_W-1:0]       mount;
        logic [SIZE_W-1:0]                 radius;
        logic [NAXIS-1:0][SIZE_W-1:0]      half;
    } t_shape;

    typedef struct packed {
        logic [NCORNER-1:0]                mask;
        logic [NCORNER-1:0][PEN_W-1:0]     pen;
        logic [NAXIS-1:0][CTR_W-1:0]       ctr;
        logic [NAXIS-1:0][OFS_W-1:0]       ofs;
    } t_hits;

    typedef struct packed {
        logic [NAXIS-1:0][POS_W-1:0]       point;
        logic [PEN_W-1:0]                  pen;
        logic [CORNER_W-1:0]               corner;
        logic                              last;
    } t_contact;

endpackage

`default_nettype wire

FILE: rtl/pcg_pipe.sv
// Six-stage arithmetic pipeline: center, products, dot sums, corner sums, distances.
// Depends on pcg_pkg.
`default_nettype none

module pcg_pipe (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pcg_pkg::t_plane  i_plane,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire pcg_pkg::t_shape  i_shape,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output pcg_pkg::t_hits        o_hits
);
    import pcg_pkg::*;

    localparam int PA_W   = CTR_W + NRM_W;        // center * normal
    localparam int PB_W   = SIZE_W + 1 + NRM_W;   // size * normal
    localparam int ACC_W  = PA_W + 3;             // dot product with corner terms
    localparam int DIST_W = ACC_W - NRM_FRAC + 3;

    logic adv;
    logic [5:0] r_vld;

    logic signed [NRM_W-1:0] nrm [NAXIS];

    // stage 1
    t_shape r1_shape;
    // stage 2
    logic signed [CTR_W-1:0]  n2_ctr [NAXIS];
    logic [SIZE_W-1:0]        n2_size [NAXIS];
    logic signed [CTR_W-1:0]  r2_ctr [NAXIS];
    logic [SIZE_W-1:0]        r2_size [NAXIS];
    logic                     r2_box;
    // stage 3
    logic signed [PA_W-1:0]   n3_a [NAXIS];
    logic signed [PB_W-1:0]   n3_b [NAXIS];
    logic signed [PA_W-1:0]   r3_a [NAXIS];
    logic signed [PB_W-1:0]   r3_b [NAXIS];
    logic signed [CTR_W-1:0]  r3_ctr [NAXIS];
    logic [SIZE_W-1:0]        r3_size [NAXIS];
    logic                     r3_box;
    // stage 4
    logic signed [ACC_W-1:0]  n4_dot;
    logic signed [ACC_W-1:0]  n4_q [4];
    logic signed [ACC_W-1:0]  n4_b2;
    logic signed [OFS_W-1:0]  n4_ofs [NAXIS];
    logic signed [ACC_W-1:0]  r4_dot;
    logic signed [ACC_W-1:0]  r4_q [4];
    logic signed [ACC_W-1:0]  r4_b2;
    logic signed [OFS_W-1:0]  r4_ofs [NAXIS];
    logic signed [CTR_W-1:0]  r4_ctr [NAXIS];
    logic [SIZE_W-1:0]        r4_rsub;
    logic                     r4_box;
    // stage 5
    logic signed [ACC_W-1:0]  n5_acc [NCORNER];
    logic signed [ACC_W-1:0]  r5_acc [NCORNER];
    logic signed [OFS_W-1:0]  r5_ofs [NAXIS];
    logic signed [CTR_W-1:0]  r5_ctr [NAXIS];
    logic [SIZE_W-1:0]        r5_rsub;
    logic                     r5_box;
    // stage 6
    logic signed [DIST_W-1:0] n6_dist [NCORNER];
    logic [DIST_W-1:0]        n6_neg [NCORNER];
    t_hits                    n6_hits;
    t_hits                    r6_hits;

    assign nrm[0] = i_plane.nx;
    assign nrm[1] = i_plane.ny;
    assign nrm[2] = i_plane.nz;

    // hold every stage while the last one waits
    assign adv     = !r_vld[5] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[5];
    assign o_hits  = r6_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            n2_ctr[i]  = CTR_W'($signed(r1_shape.pos[i])) + CTR_W'($signed(r1_shape.mount[i]));
            n2_size[i] = r1_shape.box ? r1_shape.half[i] : r1_shape.radius;
        end
    end

    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            n3_a[i] = PA_W'(r2_ctr[i]) * PA_W'(nrm[i]);
            n3_b[i] = PB_W'($signed({1'b0, r2_size[i]})) * PB_W'(nrm[i]);
        end
    end

    // box: corner terms +/- size*n; sphere: no corner terms, offset -floor(n*r)
    always_comb begin
        logic signed [ACC_W-1:0] b0;
        logic signed [ACC_W-1:0] b1;
        b0 = ACC_W'(r3_b[0]);
        b1 = ACC_W'(r3_b[1]);
        n4_dot = ACC_W'(r3_a[0]) + ACC_W'(r3_a[1]) + ACC_W'(r3_a[2]);
        for (int j = 0; j < 4; j++) begin
            if (r3_box) begin
                n4_q[j] = (j[0] ? -b0 : b0) + (j[1] ? -b1 : b1);
            end else begin
                n4_q[j] = '0;
            end
        end
        n4_b2 = r3_box ? ACC_W'(r3_b[2]) : '0;
        for (int i = 0; i < NAXIS; i++) begin
            if (r3_box) begin
                n4_ofs[i] = $signed(OFS_W'(r3_size[i]));
            end else begin
                n4_ofs[i] = -OFS_W'(r3_b[i] >>> NRM_FRAC);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NCORNER; k++) begin
            n5_acc[k] = r4_dot + r4_q[k[1:0]] + (k[2] ? -r4_b2 : r4_b2);
        end
    end

    always_comb begin
        n6_hits = '0;
        for (int k = 0; k < NCORNER; k++) begin
            n6_dist[k] = DIST_W'(r5_acc[k] >>> NRM_FRAC) - DIST_W'(i_plane.offset)
                       - $signed(DIST_W'(r5_rsub));
            n6_neg[k]  = -n6_dist[k];
            n6_hits.mask[k] = (n6_dist[k] <= 0) && (r5_box || k == 0);
            if (n6_neg[k][DIST_W-1:PEN_W] != '0) begin
                n6_hits.pen[k] = '1;
            end else begin
                n6_hits.pen[k] = n6_neg[k][PEN_W-1:0];
            end
        end
        for (int i = 0; i < NAXIS; i++) begin
            n6_hits.ctr[i] = r5_ctr[i];
            n6_hits.ofs[i] = r5_ofs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_shape <= i_shape;
            r2_box   <= r1_shape.box;
            r3_box   <= r2_box;
            r4_box   <= r3_box;
            r5_box   <= r4_box;
            r4_dot   <= n4_dot;
            r4_b2    <= n4_b2;
            r4_rsub  <= r3_box ? '0 : r3_size[0];
            r5_rsub  <= r4_rsub;
            for (int i = 0; i < NAXIS; i++) begin
                r2_ctr[i]  <= n2_ctr[i];
                r2_size[i] <= n2_size[i];
                r3_a[i]    <= n3_a[i];
                r3_b[i]    <= n3_b[i];
                r3_ctr[i]  <= r2_ctr[i];
                r3_size[i] <= r2_size[i];
                r4_ofs[i]  <= n4_ofs[i];
                r4_ctr[i]  <= r3_ctr[i];
                r5_ofs[i]  <= r4_ofs[i];
                r5_ctr[i]  <= r4_ctr[i];
            end
            for (int j = 0; j < 4; j++) begin
                r4_q[j] <= n4_q[j];
            end
            for (int k = 0; k < NCORNER; k++) begin
                r5_acc[k] <= n5_acc[k];
            end
            r6_hits <= n6_hits;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcg_emit.sv
// Contact serializer: walks the hit mask of one item into a registered output,
// one contact per cycle while i_ready does not hold the output. Depends on pcg_pkg.
`default_nettype none

module pcg_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire pcg_pkg::t_hits   i_hits,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output pcg_pkg::t_contact     o_contact
);
    import pcg_pkg::*;

    logic [NCORNER-1:0]  r_mask;
    t_hits               r_hits;
    logic                r_out_valid;
    t_contact            r_contact;

    logic                out_free;
    logic                emit;
    logic [NCORNER-1:0]  mask_rest;
    logic [CORNER_W-1:0] sel;
    t_contact            n_contact;

    function automatic logic [POS_W-1:0] sat_point(input logic signed [PT_W-1:0] v);
        if (v[PT_W-1:POS_W-1] == '0 || v[PT_W-1:POS_W-1] == '1) begin
            return v[POS_W-1:0];
        end else if (v[PT_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    assign out_free  = !r_out_valid || i_ready;
    assign emit      = (r_mask != '0) && out_free;
    assign mask_rest = r_mask & (r_mask - NCORNER'(1));
    // take the next item once the current one is on its final contact
    assign o_ready   = (r_mask == '0) || (out_free && mask_rest == '0);
    assign o_valid   = r_out_valid;
    assign o_contact = r_contact;

    always_comb begin
        sel = '0;
        for (int k = NCORNER - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = CORNER_W'(k);
            end
        end
    end

    always_comb begin
        logic signed [PT_W-1:0] c;
        logic signed [PT_W-1:0] o;
        n_contact = '0;
        for (int i = 0; i < NAXIS; i++) begin
            c = PT_W'($signed(r_hits.ctr[i]));
            o = PT_W'($signed(r_hits.ofs[i]));
            n_contact.point[i] = sat_point(sel[i] ? c - o : c + o);
        end
        n_contact.pen    = r_hits.pen[sel];
        n_contact.corner = sel;
        n_contact.last   = (mask_rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_mask <= i_hits.mask;
            end else if (emit) begin
                r_mask <= mask_rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_hits <= i_hits;
        end
        if (emit) begin
            r_contact <= n_contact;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/plane_contact_generator.sv
// Top level of the plane contact generator: plane registers, stream ports.
// Depends on pcg_pkg, pcg_pipe and pcg_emit.
//
// Use: each s_axis transaction carries one shape (tuser: 0 sphere, 1 box) with
// body position, mount translation and radius or half sizes. The shape is
// tested against the plane n.x = d held in four registers written through
// i_cfg_we / i_cfg_index / i_cfg_data (normal x, y, z in Q1.15, then d in
// Q16.16). Write them only while the block is idle.
// Each m_axis transaction is one contact: point, penetration and corner, with
// tlast on the final contact of its shape. A shape with no contact produces
// nothing on m_axis.
// Path: the first contact reaches m_axis through the input register, five
// compute stages and the contact serializer.
// Throughput: while m_axis_tready is high the serializer emits one contact per
// cycle and takes one shape per cycle for spheres and for boxes with at most one
// contact; a box fully below the plane holds it until all eight contacts are out.
// The six stages in front fill while it works, until the last holds a shape.
// Stall: when m_axis_tready is low, hold the output contact, then the
// serializer, then all pipeline stages together; s_axis_tready falls once
// the last stage holds a shape. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): empty the pipeline and output, normal
// returns to (0, 0x7FFF, 0) and d to 0.
`default_nettype none

module plane_contact_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [pcg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [pcg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // shapes in
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // pos_x, pos_y, pos_z, mount_x, mount_y, mount_z (32 each), radius,
    // half_x, half_y, half_z (31 each), 4 zero bits
    input  wire logic [pcg_pkg::S_TDATA_W-1:0]         s_axis_tdata,
    input  wire logic                                  s_axis_tuser,   // box select
    // contacts out
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // point_x, point_y, point_z (32 each), penetration (31), corner (3),
    // 6 zero bits
    output logic [pcg_pkg::M_TDATA_W-1:0]              m_axis_tdata,
    output logic                                       m_axis_tlast    // last
);
    import pcg_pkg::*;

    localparam int SZ0 = NAXIS * POS_W * 2;    // first size field bit

    logic [NRM_W-1:0] r_nx;
    logic [NRM_W-1:0] r_ny;
    logic [NRM_W-1:0] r_nz;
    logic [POS_W-1:0] r_d;

    t_plane   plane;
    t_shape   shape;
    t_hits    hits;
    logic     hits_valid;
    logic     hits_ready;
    t_contact contact;

    // plane registers; unknown indexes cannot occur with a two-bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= NORMAL_X_RST;
            r_ny <= NORMAL_Y_RST;
            r_nz <= NORMAL_Z_RST;
            r_d  <= PLANE_D_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NORMAL_X: r_nx <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y: r_ny <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Z: r_nz <= i_cfg_data[NRM_W-1:0];
                CFG_PLANE_D:  r_d  <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign plane.nx     = $signed(r_nx);
    assign plane.ny     = $signed(r_ny);
    assign plane.nz     = $signed(r_nz);
    assign plane.offset = $signed(r_d);

    // unpack the shape transaction
    always_comb begin
        shape.box = s_axis_tuser;
        for (int i = 0; i < NAXIS; i++) begin
            shape.pos[i]   = s_axis_tdata[i*POS_W +: POS_W];
            shape.mount[i] = s_axis_tdata[(NAXIS + i)*POS_W +: POS_W];
            shape.half[i]  = s_axis_tdata[SZ0 + (i + 1)*SIZE_W +: SIZE_W];
        end
        shape.radius = s_axis_tdata[SZ0 +: SIZE_W];
    end

    pcg_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_plane (plane),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_shape (shape),
        .o_valid (hits_valid),
        .i_ready (hits_ready),
        .o_hits  (hits)
    );

    pcg_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (hits_valid),
        .o_ready   (hits_ready),
        .i_hits    (hits),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_contact (contact)
    );

    // pack the contact transaction
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < NAXIS; i++) begin
            m_axis_tdata[i*POS_W +: POS_W] = contact.point[i];
        end
        m_axis_tdata[NAXIS*POS_W +: PEN_W]            = contact.pen;
        m_axis_tdata[NAXIS*POS_W + PEN_W +: CORNER_W] = contact.corner;
    end

    assign m_axis_tlast = contact.last;

endmodule

`default_nettype wire
